// File: design/htm_pkg.sv
`default_nettype none
package htm_pkg;

	// Sizes
	localparam int MAX_LEVEL_DEF   = 13;
	localparam int LEV_W           = 4;
	localparam int ID_W            = 30;
	localparam int CW              = 32;
	localparam int ROOT_BASE       = 8;

	// Iterative units: steps per square root / divide and steps per stage
	localparam int SQ_STEPS        = 32;
	localparam int DIV_STEPS       = 32;
	localparam int STEPS_PER_STAGE = 4;
	localparam int SQ_STAGES       = SQ_STEPS / STEPS_PER_STAGE;
	localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

	// Latencies in cycles
	localparam int MID_LAT         = 3 + SQ_STAGES + DIV_STAGES + 1;
	localparam int SIDE_LAT        = 5;
	localparam int LEVEL_LAT       = MID_LAT + SIDE_LAT + 1;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;
	typedef logic [2:0][CW-1:0] vraw_t;
	typedef logic [ID_W-1:0] id_t;
	typedef logic [LEV_W-1:0] lev_t;

	// One point on its way down the levels
	typedef struct packed {
		vec_t p;
		vec_t v0;
		vec_t v1;
		vec_t v2;
		id_t  id;
		lev_t lev;
	} item_t;

	typedef struct packed {
		vec_t v0;
		vec_t v1;
		vec_t v2;
	} tri_t;

	typedef enum logic [1:0] {
		CHILD_0,
		CHILD_1,
		CHILD_2,
		CHILD_3
	} child_t;

	// Square root and divider working state
	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] quo;
	} dv_t;

	localparam coord_t Q_ONE  = 32'sh4000_0000;
	localparam coord_t Q_MONE = 32'shC000_0000;
	localparam coord_t Q_ZERO = 32'sh0000_0000;

	localparam vec_t VX_P = {Q_ONE,  Q_ZERO, Q_ZERO};
	localparam vec_t VX_N = {Q_MONE, Q_ZERO, Q_ZERO};
	localparam vec_t VY_P = {Q_ZERO, Q_ONE,  Q_ZERO};
	localparam vec_t VY_N = {Q_ZERO, Q_MONE, Q_ZERO};
	localparam vec_t VZ_P = {Q_ZERO, Q_ZERO, Q_ONE};
	localparam vec_t VZ_N = {Q_ZERO, Q_ZERO, Q_MONE};

	// Root triangle from the signs of z, y, x
	function automatic logic [2:0] root_of(coord_t x, coord_t y, coord_t z);
		logic [2:0] r;
		if (z < 0) begin
			if (y > 0)       r = (x > 0)  ? 3'd0 : 3'd1;
			else if (y == 0) r = (x >= 0) ? 3'd0 : 3'd2;
			else             r = (x < 0)  ? 3'd2 : 3'd3;
		end else begin
			if (y > 0)       r = (x > 0)  ? 3'd7 : 3'd6;
			else if (y == 0) r = (x >= 0) ? 3'd7 : 3'd5;
			else             r = (x < 0)  ? 3'd5 : 3'd4;
		end
		return r;
	endfunction

	// Root vertex table
	function automatic tri_t root_tri(logic [2:0] r);
		tri_t t;
		case (r)
			3'd0:    t = {VX_P, VZ_N, VY_P};
			3'd1:    t = {VY_P, VZ_N, VX_N};
			3'd2:    t = {VX_N, VZ_N, VY_N};
			3'd3:    t = {VY_N, VZ_N, VX_P};
			3'd4:    t = {VX_P, VZ_P, VY_N};
			3'd5:    t = {VY_N, VZ_P, VX_N};
			3'd6:    t = {VX_N, VZ_P, VY_P};
			default: t = {VY_P, VZ_P, VX_P};
		endcase
		return t;
	endfunction

	// One digit of the restoring square root
	function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
		logic [35:0] r;
		logic [35:0] t;
		sq_t o;
		r = {a.rem[33:0], pair};
		t = {2'b00, a.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {a.root[30:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic sq_t sqrt_stage(sq_t a, logic [2*STEPS_PER_STAGE-1:0] bits);
		sq_t t;
		t = a;
		for (int j = 0; j < STEPS_PER_STAGE; j++)
			t = sqrt_step(t, bits[2*(STEPS_PER_STAGE-1-j) +: 2]);
		return t;
	endfunction

	// One bit of the restoring divider, remainder kept below d
	function automatic dv_t div_step(dv_t a, logic nbit, logic [32:0] d);
		logic [33:0] r;
		dv_t o;
		r = {a.rem, nbit};
		if (r >= {1'b0, d}) begin
			o.rem = 33'(r - {1'b0, d});
			o.quo = {a.quo[30:0], 1'b1};
		end else begin
			o.rem = r[32:0];
			o.quo = {a.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dv_t div_stage(dv_t a, logic [STEPS_PER_STAGE-1:0] bits,
			logic [32:0] d);
		dv_t t;
		t = a;
		for (int j = 0; j < STEPS_PER_STAGE; j++)
			t = div_step(t, bits[STEPS_PER_STAGE-1-j], d);
		return t;
	endfunction

endpackage
`default_nettype wire

// File: design/htm_point_index.sv
`default_nettype none
// Hierarchical triangular mesh point index.
// A point (coord_x, coord_y, coord_z, signed Q1.30) is taken at a rising
// edge with start high and busy low. busy is always low: a new point may
// be started in every cycle. The index at the configured level appears
// on mesh_index for one cycle with done high, in start order. Throughput
// is one point per cycle.
// Each level is a fixed 26 stage section: midpoint units (32 digit
// square root and 32 bit divider, four steps a stage), exact sign tests,
// and the child select. Levels past level_count pass the word through.
// level_count is written with level_we and is sampled when a point is
// started; values above MAX_LEVEL act as MAX_LEVEL.
// Reset clears level_count and all valid bits; no result is delivered
// for points in flight at reset. The receiver cannot stall the output.
module htm_point_index import htm_pkg::*; #(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic             level_we,
	input  logic [3:0]       level_count,
	output logic             done,
	output logic [29:0]      mesh_index
);

	assign busy = 1'b0;

	// level register
	lev_t level_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (level_we) begin
			level_q <= level_count;
		end
	end

	// root selection
	logic [2:0] root_c;
	tri_t       tri_c;
	item_t      root_item;
	assign root_c = root_of(coord_x, coord_y, coord_z);
	assign tri_c  = root_tri(root_c);

	always_comb begin
		root_item.p   = {coord_x, coord_y, coord_z};
		root_item.v0  = tri_c.v0;
		root_item.v1  = tri_c.v1;
		root_item.v2  = tri_c.v2;
		root_item.id  = ID_W'(ROOT_BASE) | ID_W'(root_c);
		root_item.lev = (level_q > LEV_W'(MAX_LEVEL)) ? LEV_W'(MAX_LEVEL) : level_q;
	end

	// level chain; entry 0 is the root register
	item_t chain_item  [MAX_LEVEL+1];
	logic  chain_valid [MAX_LEVEL+1];
	item_t root_q;
	logic  root_valid_q;

	always_ff @(posedge clk) begin
		root_q <= root_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q <= 1'b0;
		end else begin
			root_valid_q <= start & !busy;
		end
	end

	assign chain_item[0]  = root_q;
	assign chain_valid[0] = root_valid_q;

	for (genvar g = 0; g < MAX_LEVEL; g++) begin : g_level
		htm_level #(.LEVEL_NUM(g)) u_level (
			.clk,
			.arst_n,
			.in_valid (chain_valid[g]),
			.in_item  (chain_item[g]),
			.out_valid(chain_valid[g+1]),
			.out_item (chain_item[g+1])
		);
	end

	assign done       = chain_valid[MAX_LEVEL];
	assign mesh_index = chain_item[MAX_LEVEL].id;

endmodule
`default_nettype wire

// File: design/htm_midpoint.sv
`default_nettype none
// Normalised midpoint of two unit vertices: s = a + b, n = isqrt(|s|^2),
// each component round(s * 2^30 / n), ties away from zero.
module htm_midpoint import htm_pkg::*; (
	input  logic clk,
	input  vec_t a,
	input  vec_t b,
	output vec_t mid
);

	vraw_t a_raw, b_raw;
	assign a_raw = vraw_t'(a);
	assign b_raw = vraw_t'(b);

	// component sums, split into sign and magnitude
	logic [2:0][32:0] sum_c;
	vraw_t            mag_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = {a_raw[i][31], a_raw[i]} + {b_raw[i][31], b_raw[i]};
			mag_c[i] = sum_c[i][32] ? 32'(-sum_c[i]) : sum_c[i][31:0];
		end
	end

	logic [2:0]       neg_s1, neg_s2, neg_s3;
	vraw_t            mag_s1, mag_s2, mag_s3;
	logic [2:0][63:0] sq_s2;
	logic [63:0]      ssum_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= sum_c[i][32];
			mag_s1[i] <= mag_c[i];
		end
		// squares
		for (int i = 0; i < 3; i++)
			sq_s2[i] <= mag_s1[i] * mag_s1[i];
		neg_s2 <= neg_s1;
		mag_s2 <= mag_s1;
		// squared norm
		ssum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		neg_s3  <= neg_s2;
		mag_s3  <= mag_s2;
	end

	// square root, STEPS_PER_STAGE digits a stage
	sq_t         sqrt_s [1:SQ_STAGES];
	logic [63:0] rad_s  [1:SQ_STAGES];
	vraw_t       magq_s [1:SQ_STAGES];
	logic [2:0]  negq_s [1:SQ_STAGES];
	sq_t         sqrt_in;
	assign sqrt_in = '0;

	always_ff @(posedge clk) begin
		sqrt_s[1] <= sqrt_stage(sqrt_in, ssum_s3[63 -: 2*STEPS_PER_STAGE]);
		rad_s[1]  <= ssum_s3 << (2*STEPS_PER_STAGE);
		magq_s[1] <= mag_s3;
		negq_s[1] <= neg_s3;
		for (int g = 1; g < SQ_STAGES; g++) begin
			sqrt_s[g+1] <= sqrt_stage(sqrt_s[g], rad_s[g][63 -: 2*STEPS_PER_STAGE]);
			rad_s[g+1]  <= rad_s[g] << (2*STEPS_PER_STAGE);
			magq_s[g+1] <= magq_s[g];
			negq_s[g+1] <= negq_s[g];
		end
	end

	// divider entry: numerator m*2^31 + n, divisor 2n
	logic [31:0]      norm;
	logic [2:0][63:0] num_c;
	dv_t  [2:0]       dv_in;
	logic [32:0]      den_c;
	assign norm  = sqrt_s[SQ_STAGES].root;
	assign den_c = {norm, 1'b0};
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i]     = {1'b0, magq_s[SQ_STAGES][i], 31'b0} + {32'b0, norm};
			dv_in[i].rem = {1'b0, num_c[i][63:32]};
			dv_in[i].quo = '0;
		end
	end

	dv_t  [2:0]       dv_s   [1:DIV_STAGES];
	logic [2:0][31:0] nlo_s  [1:DIV_STAGES];
	logic [32:0]      den_s  [1:DIV_STAGES];
	logic             nz_s   [1:DIV_STAGES];
	logic [2:0]       negd_s [1:DIV_STAGES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_s[1][i]  <= div_stage(dv_in[i], num_c[i][31 -: STEPS_PER_STAGE], den_c);
			nlo_s[1][i] <= num_c[i][31:0] << STEPS_PER_STAGE;
		end
		den_s[1]  <= den_c;
		nz_s[1]   <= (norm != '0);
		negd_s[1] <= negq_s[SQ_STAGES];
		for (int g = 1; g < DIV_STAGES; g++) begin
			for (int i = 0; i < 3; i++) begin
				dv_s[g+1][i]  <= div_stage(dv_s[g][i], nlo_s[g][i][31 -: STEPS_PER_STAGE],
					den_s[g]);
				nlo_s[g+1][i] <= nlo_s[g][i] << STEPS_PER_STAGE;
			end
			den_s[g+1]  <= den_s[g];
			nz_s[g+1]   <= nz_s[g];
			negd_s[g+1] <= negd_s[g];
		end
	end

	// sign back on; zero norm gives zero
	vraw_t       mid_q;
	logic [31:0] qv [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			qv[i] = nz_s[DIV_STAGES] ? dv_s[DIV_STAGES][i].quo : 32'd0;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			mid_q[i] <= negd_s[DIV_STAGES][i] ? 32'(-qv[i]) : qv[i];
	end

	assign mid = vec_t'(mid_q);

endmodule
`default_nettype wire

// File: design/htm_side.sv
`default_nettype none
// Exact sign test: nonneg = (p . (a x b) >= 0), five stages.
module htm_side import htm_pkg::*; (
	input  logic clk,
	input  vec_t p,
	input  vec_t a,
	input  vec_t b,
	output logic nonneg
);

	logic signed [63:0] pr_s1 [6];
	vec_t               p_s1, p_s2;
	logic signed [63:0] cx_s2, cy_s2, cz_s2;
	logic signed [64:0] lo_s3 [3];
	logic signed [63:0] hi_s3 [3];
	logic [97:0]        t_s4 [3];
	logic [99:0]        sum_c;

	always_ff @(posedge clk) begin
		// cross product terms
		pr_s1[0] <= a.y * b.z;
		pr_s1[1] <= a.z * b.y;
		pr_s1[2] <= a.z * b.x;
		pr_s1[3] <= a.x * b.z;
		pr_s1[4] <= a.x * b.y;
		pr_s1[5] <= a.y * b.x;
		p_s1     <= p;
		// cross product
		cx_s2 <= pr_s1[0] - pr_s1[1];
		cy_s2 <= pr_s1[2] - pr_s1[3];
		cz_s2 <= pr_s1[4] - pr_s1[5];
		p_s2  <= p_s1;
		// partial products, low and high halves of each component
		lo_s3[0] <= $signed({1'b0, cx_s2[31:0]}) * p_s2.x;
		lo_s3[1] <= $signed({1'b0, cy_s2[31:0]}) * p_s2.y;
		lo_s3[2] <= $signed({1'b0, cz_s2[31:0]}) * p_s2.z;
		hi_s3[0] <= $signed(cx_s2[63:32]) * p_s2.x;
		hi_s3[1] <= $signed(cy_s2[63:32]) * p_s2.y;
		hi_s3[2] <= $signed(cz_s2[63:32]) * p_s2.z;
		// recombine
		for (int i = 0; i < 3; i++)
			t_s4[i] <= {{2{hi_s3[i][63]}}, hi_s3[i], 32'b0} + {{33{lo_s3[i][64]}}, lo_s3[i]};
		// sign of the dot product
		nonneg <= !sum_c[99];
	end

	assign sum_c = {{2{t_s4[0][97]}}, t_s4[0]} + {{2{t_s4[1][97]}}, t_s4[1]}
		+ {{2{t_s4[2][97]}}, t_s4[2]};

endmodule
`default_nettype wire

// File: design/htm_level.sv
`default_nettype none
// One subdivision level: edge midpoints, a sign test per inner edge, child select.
module htm_level import htm_pkg::*; #(
	parameter int LEVEL_NUM = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	localparam int DLY = MID_LAT + SIDE_LAT;

	// edge midpoints
	vec_t m0, m1, m2;
	htm_midpoint u_mid0 (.clk, .a(in_item.v1), .b(in_item.v2), .mid(m0));
	htm_midpoint u_mid1 (.clk, .a(in_item.v2), .b(in_item.v0), .mid(m1));
	htm_midpoint u_mid2 (.clk, .a(in_item.v0), .b(in_item.v1), .mid(m2));

	// word delay alongside the arithmetic
	item_t        item_s [1:DLY];
	logic [DLY:1] valid_s;
	tri_t         mid_s  [1:SIDE_LAT];

	always_ff @(posedge clk) begin
		item_s[1] <= in_item;
		for (int k = 1; k < DLY; k++)
			item_s[k+1] <= item_s[k];
		mid_s[1] <= {m0, m1, m2};
		for (int k = 1; k < SIDE_LAT; k++)
			mid_s[k+1] <= mid_s[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[DLY-1:1], in_valid};
		end
	end

	// inner edge tests
	logic t0, t1, t2;
	htm_side u_side0 (.clk, .p(item_s[MID_LAT].p), .a(m2), .b(m1), .nonneg(t0));
	htm_side u_side1 (.clk, .p(item_s[MID_LAT].p), .a(m0), .b(m2), .nonneg(t1));
	htm_side u_side2 (.clk, .p(item_s[MID_LAT].p), .a(m1), .b(m0), .nonneg(t2));

	// child select; levels beyond the configured count pass through
	item_t  cur, nxt;
	tri_t   md;
	child_t child_c;
	assign cur = item_s[DLY];
	assign md  = mid_s[SIDE_LAT];

	always_comb begin
		nxt = cur;
		if (t0) begin
			child_c = CHILD_0;
			nxt.v1  = md.v2;
			nxt.v2  = md.v1;
		end else if (t1) begin
			child_c = CHILD_1;
			nxt.v0  = cur.v1;
			nxt.v1  = md.v0;
			nxt.v2  = md.v2;
		end else if (t2) begin
			child_c = CHILD_2;
			nxt.v0  = cur.v2;
			nxt.v1  = md.v1;
			nxt.v2  = md.v0;
		end else begin
			child_c = CHILD_3;
			nxt.v0  = md.v0;
			nxt.v1  = md.v1;
			nxt.v2  = md.v2;
		end
		nxt.id = {cur.id[ID_W-3:0], child_c};
		if (cur.lev <= LEV_W'(LEVEL_NUM))
			nxt = cur;
	end

	always_ff @(posedge clk) begin
		out_item <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s[DLY];
		end
	end

endmodule
`default_nettype wire
